// ----- rtl/sss_pkg.sv -----
`default_nettype none

package sss_pkg;

   // Field widths of the words on the three channels.
   localparam int VALUE_W    = 14;
   localparam int DWELL_W    = 16;
   localparam int ENABLE_W   = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam int NUM_DIGITS = 4;
   localparam int SEG_W      = 8;

   localparam logic [VALUE_W-1:0] MAX_VALUE   = 14'd9999;
   localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd20;
   localparam int                 QUEUE_DEPTH = 2;

   // Index of the last bit within a digit; the slot after it is the enable word.
   localparam logic [3:0] LAST_SHIFT_SLOT = 4'd7;
   localparam logic [3:0] ENABLE_SLOT     = 4'd8;
   localparam logic [1:0] LAST_DIGIT      = 2'd3;
   localparam logic [1:0] LAST_SPLIT_STEP = 2'd2;

   // Segment bytes of the four digits, thousands in byte 0.
   typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] seg_codes_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SPLIT,
      FRONT_PUSH
   } front_state_type;

   // Segment pattern of a decimal digit, bit 0 is segment a.
   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      case (digit)
         4'd0: code = 8'b0011_1111;
         4'd1: code = 8'b0000_0110;
         4'd2: code = 8'b0101_1011;
         4'd3: code = 8'b0100_1111;
         4'd4: code = 8'b0110_0110;
         4'd5: code = 8'b0110_1101;
         4'd6: code = 8'b0111_1101;
         4'd7: code = 8'b0000_0111;
         4'd8: code = 8'b0111_1111;
         default: code = 8'b0110_1111;
      endcase
      return code;
   endfunction

   // k times the decimal weight handled at a split step (1000, 100, 10).
   function automatic logic [VALUE_W-1:0] place_multiple(input logic [1:0] step,
                                                         input int k);
      logic [VALUE_W-1:0] mult;
      case (step)
         2'd0: mult = VALUE_W'(k * 1000);
         2'd1: mult = VALUE_W'(k * 100);
         default: mult = VALUE_W'(k * 10);
      endcase
      return mult;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sss_front.sv -----
`default_nettype none

// Takes a number, saturates it and splits it into four segment bytes,
// one decimal digit per split step and the tens and units together in the last step, then hands the bytes to the queue.
module sss_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [sss_pkg::VALUE_W-1:0]   req_value,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output sss_pkg::seg_codes_type             push_codes
);

   sss_pkg::front_state_type state_ff, state_in;
   logic [sss_pkg::VALUE_W-1:0] rem_ff, rem_in;
   logic [1:0]                  step_ff, step_in;
   sss_pkg::seg_codes_type      codes_ff, codes_in;

   logic [3:0]                  digit;
   logic [sss_pkg::VALUE_W-1:0] digit_sub;
   logic [sss_pkg::VALUE_W-1:0] rem_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sss_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      codes_ff <= codes_in;
   end

   // The remainder is always below ten times the current weight, so the
   // digit is the largest multiple that still fits.
   always_comb begin
      digit     = '0;
      digit_sub = '0;
      for (int k = 1; k <= 9; k++) begin
         if (rem_ff >= sss_pkg::place_multiple(step_ff, k)) begin
            digit     = 4'(k);
            digit_sub = sss_pkg::place_multiple(step_ff, k);
         end
      end
      rem_left = rem_ff - digit_sub;
   end

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      codes_in   = codes_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         sss_pkg::FRONT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rem_in   = (req_value > sss_pkg::MAX_VALUE) ? sss_pkg::MAX_VALUE : req_value;
               step_in  = '0;
               state_in = sss_pkg::FRONT_SPLIT;
            end
         end
         sss_pkg::FRONT_SPLIT: begin
            codes_in[step_ff] = sss_pkg::seg_code(digit);
            rem_in            = rem_left;
            if (step_ff == sss_pkg::LAST_SPLIT_STEP) begin
               codes_in[sss_pkg::LAST_DIGIT] = sss_pkg::seg_code(rem_left[3:0]);
               state_in = sss_pkg::FRONT_PUSH;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         sss_pkg::FRONT_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = sss_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = sss_pkg::FRONT_IDLE;
         end
      endcase
   end

   assign push_codes = codes_ff;

   a_split_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == sss_pkg::FRONT_SPLIT |-> step_ff <= sss_pkg::LAST_SPLIT_STEP)
      else $error("front split step out of range");

   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == sss_pkg::FRONT_SPLIT |-> rem_ff <= sss_pkg::MAX_VALUE)
      else $error("front remainder above saturation limit");

endmodule

`default_nettype wire

// ----- rtl/sss_queue.sv -----
`default_nettype none

// Small first-in first-out queue between the front and the back.
module sss_queue #(
   parameter int Width = 32,
   parameter int Depth = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [Width-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [Width-1:0]      pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(Depth);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;

   logic do_push, do_pop;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- rtl/sss_back.sv -----
`default_nettype none

// Walks the four segment bytes of one entry and drives one result word
// per cycle into the output register while the receiver takes words:
// eight shift words, then one enable word, for each digit.
module sss_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire sss_pkg::seg_codes_type            pop_codes,
   input  wire logic [sss_pkg::DWELL_W-1:0]       dwell,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sss_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   logic                   busy_ff, busy_in;
   sss_pkg::seg_codes_type codes_ff, codes_in;
   logic [3:0]             slot_ff, slot_in;
   logic [1:0]             digit_ff, digit_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sss_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                               rsp_user_ff, rsp_user_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               out_load;
   logic                               serial_bit;
   logic [sss_pkg::ENABLE_W-1:0]       enable_sel;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign serial_bit = codes_ff[0][3'd7 - slot_ff[2:0]];
   assign enable_sel = sss_pkg::ENABLE_W'(1) << digit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      codes_ff    <= codes_in;
      slot_ff     <= slot_in;
      digit_ff    <= digit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      busy_in      = busy_ff;
      codes_in     = codes_ff;
      slot_in      = slot_ff;
      digit_in     = digit_ff;
      pop_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      if (busy_ff && out_load) begin
         rsp_valid_in = 1'b1;
         if (slot_ff == sss_pkg::ENABLE_SLOT) begin
            // Enable word: select the digit and carry the dwell time.
            rsp_data_in = {3'b000, dwell, enable_sel, 1'b0};
            rsp_user_in = 1'b0;
            rsp_last_in = (digit_ff == sss_pkg::LAST_DIGIT);
            slot_in     = '0;
            codes_in    = codes_ff >> sss_pkg::SEG_W;
            digit_in    = digit_ff + 2'd1;
            if (digit_ff == sss_pkg::LAST_DIGIT) begin
               // Chain straight into the next entry, when one is waiting, so runs follow without a gap.
               busy_in   = pop_valid;
               pop_ready = pop_valid;
               codes_in  = pop_codes;
               digit_in  = '0;
            end
         end else begin
            rsp_data_in = {23'd0, serial_bit};
            rsp_user_in = 1'b1;
            rsp_last_in = 1'b0;
            slot_in     = slot_ff + 4'd1;
         end
      end else if (!busy_ff && pop_valid) begin
         pop_ready = 1'b1;
         busy_in   = 1'b1;
         codes_in  = pop_codes;
         slot_in   = '0;
         digit_in  = '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_last_is_units: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_data_ff[4:1] == 4'b1000 && !rsp_user_ff)
      else $error("last word of a run does not enable the units digit");

   a_shift_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_data_ff[20:1] == 20'd0)
      else $error("shift word carries an enable or hold value");

   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_user_ff |-> $onehot(rsp_data_ff[4:1]))
      else $error("enable word without a one-hot digit select");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> slot_ff <= sss_pkg::ENABLE_SLOT)
      else $error("back slot counter out of range");

endmodule

`default_nettype wire

// ----- rtl/seven_segment_scan_serializer.sv -----
// Four-digit multiplexed seven-segment scan serializer.
//
// The req channel takes one word per number to show; values above 9999
// are shown as 9999. For each number the rsp channel delivers a run of 36
// words: for each digit, thousands first, eight shift words (tuser high)
// that carry the segment byte MSB first in the serial bit, then one enable
// word (tuser low) with the one-hot digit select and the dwell time. The
// enable word of the units digit carries tlast.
// The csr channel writes the dwell time in microseconds; it is always
// ready and should only be written while no run is in flight.
// When the back end is idle, an accepted number passes through these steps
// to its first result: the front end splits off the decimal digits, the
// segment bytes enter the queue, the back end takes the entry and the
// output register loads. Throughput is one result per cycle while the
// receiver takes them, set by the back end that emits one word a cycle.
// The front end accepts the next number while the back end is still busy,
// with a queue of QueueDepth entries between them.
// Reset empties the queue, drops any pending run and sets the dwell time
// to 20. When the receiver stalls, the output register holds its word, the
// back end waits, and once the queue fills req_tready goes low.

`default_nettype none

module seven_segment_scan_serializer #(
   parameter int QueueDepth = sss_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: display_value [13:0], zero above.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [sss_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: serial_bit [0], digit_enable [4:1], hold_time [20:5], zero above.
   // rsp_tuser: shift_pulse. rsp_tlast: last_of_run.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [sss_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   // csr_tdata: dwell_microseconds [15:0].
   input  wire logic                               csr_tvalid,
   output logic                                    csr_tready,
   input  wire logic [sss_pkg::DWELL_W-1:0]        csr_tdata
);

   localparam int CodesW = sss_pkg::NUM_DIGITS * sss_pkg::SEG_W;

   logic [sss_pkg::DWELL_W-1:0] dwell_ff;

   logic                   push_valid, push_ready;
   sss_pkg::seg_codes_type push_codes;
   logic                   pop_valid, pop_ready;
   logic [CodesW-1:0]      pop_data;

   // The dwell register is written whenever the csr channel offers a word.
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff <= sss_pkg::DWELL_RESET;
      end else if (csr_tvalid) begin
         dwell_ff <= csr_tdata;
      end
   end

   // Front end: capture, saturate and convert to segment bytes.
   sss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  (req_tdata[sss_pkg::VALUE_W-1:0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_codes (push_codes)
   );

   // Queue of converted numbers waiting for the back end.
   sss_queue #(
      .Width (CodesW),
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_codes),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: serialize each entry into its 36-word run.
   sss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_codes  (sss_pkg::seg_codes_type'(pop_data)),
      .dwell      (dwell_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
